[hdl/fgr_pkg.sv]
package fgr_pkg;

  // Fade length in frames; a power of two, so the divide by it is a shift
  localparam int FADE_FRAMES = 512;
  localparam int FADE_SHIFT  = $clog2(FADE_FRAMES);
  // Gain step k runs 1..FADE_FRAMES
  localparam int GAIN_W      = $clog2(FADE_FRAMES + 1);

  // Default build parameters
  localparam int MAX_CHANNELS_DEF = 8;

  // Field and port widths
  localparam int SAMPLE_W   = 32;
  localparam int CC_W       = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index sits above the byte offset within a word
  localparam int REG_IDX_LSB = 2;

  // Reset value of the channel count register
  localparam logic [CC_W-1:0] CC_RESET = 4'd2;

  typedef enum logic {
    REG_SAMPLE_WIDTH_MODE = 1'b0,
    REG_CHANNEL_COUNT     = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_S16 = 1'b0,
    MODE_S32 = 1'b1
  } width_mode_t;

  typedef enum logic {
    CMD_PROCESS = 1'b0,
    CMD_ARM     = 1'b1
  } command_t;

  typedef struct packed {
    width_mode_t     mode;
    logic [CC_W-1:0] channel_count;
  } cfg_t;

endpackage

[hdl/fgr_cfg.sv]
module fgr_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fgr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fgr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fgr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output fgr_pkg::cfg_t                    cfg
);

  fgr_pkg::reg_idx_t         idx;
  fgr_pkg::width_mode_t      mode_r;
  logic [fgr_pkg::CC_W-1:0]  cc_r;
  logic                      wr_en;

  assign pready = 1'b1;
  assign idx    = fgr_pkg::reg_idx_t'(paddr[fgr_pkg::REG_IDX_LSB]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fgr_pkg::MODE_S16;
      cc_r   <= fgr_pkg::CC_RESET;
    end else if (wr_en) begin
      case (idx)
        fgr_pkg::REG_SAMPLE_WIDTH_MODE: mode_r <= fgr_pkg::width_mode_t'(pwdata[0]);
        fgr_pkg::REG_CHANNEL_COUNT:     cc_r   <= pwdata[fgr_pkg::CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fgr_pkg::REG_SAMPLE_WIDTH_MODE:
        prdata = {{(fgr_pkg::CFG_DATA_W-1){1'b0}}, mode_r};
      fgr_pkg::REG_CHANNEL_COUNT:
        prdata = {{(fgr_pkg::CFG_DATA_W-fgr_pkg::CC_W){1'b0}}, cc_r};
      default:
        prdata = '0;
    endcase
  end

  assign cfg.mode          = mode_r;
  assign cfg.channel_count = cc_r;

endmodule

[hdl/fgr_ctrl.sv]
module fgr_ctrl #(
  parameter int MAX_CHANNELS = fgr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fgr_pkg::cfg_t                      cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [fgr_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                               st_valid,
  input  logic                               st_ready,
  output logic [fgr_pkg::SAMPLE_W-1:0]       st_mag,
  output logic [fgr_pkg::GAIN_W-1:0]         st_k,
  output logic                               st_neg,
  output logic                               st_applied
);

  localparam int KW = fgr_pkg::GAIN_W;
  localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int EW = ($clog2(MAX_CHANNELS + 1) > fgr_pkg::CC_W) ?
                      $clog2(MAX_CHANNELS + 1) : fgr_pkg::CC_W;
  localparam logic [KW-1:0] FADE_LAST = KW'(fgr_pkg::FADE_FRAMES);
  localparam logic [EW-1:0] MAX_EFF   = EW'(MAX_CHANNELS);

  logic [KW-1:0]                 left_r, left_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [EW-1:0]                 cc_ext, eff, pos_inc;
  logic                          fire, arm, proc, fading;
  logic [fgr_pkg::SAMPLE_W-1:0]  v, mag;
  logic                          neg;
  logic [KW-1:0]                 k;

  logic                          st_valid_r;
  logic [fgr_pkg::SAMPLE_W-1:0]  st_mag_r;
  logic [KW-1:0]                 st_k_r;
  logic                          st_neg_r, st_applied_r;

  assign in_ready = !st_valid_r || st_ready;
  assign fire     = in_valid && in_ready;
  assign arm      = fire && (fgr_pkg::command_t'(in_command) == fgr_pkg::CMD_ARM);
  assign proc     = fire && (fgr_pkg::command_t'(in_command) == fgr_pkg::CMD_PROCESS);
  assign fading   = (left_r != '0);

  // Effective channel count: zero reads as one, saturate at the maximum
  always_comb begin
    cc_ext = EW'(cfg.channel_count);
    if (cc_ext == '0) begin
      eff = EW'(1);
    end else if (cc_ext > MAX_EFF) begin
      eff = MAX_EFF;
    end else begin
      eff = cc_ext;
    end
  end

  assign pos_inc = EW'(pos_r) + EW'(1);

  always_comb begin
    left_nxt = left_r;
    pos_nxt  = pos_r;
    if (arm) begin
      left_nxt = FADE_LAST;
      pos_nxt  = '0;
    end else if (proc) begin
      if (pos_inc >= eff) begin
        pos_nxt = '0;
        if (fading) begin
          left_nxt = left_r - KW'(1);
        end
      end else begin
        pos_nxt = pos_inc[PW-1:0];
      end
    end
  end

  // Sign-extend the active width and split into sign and magnitude
  always_comb begin
    if (cfg.mode == fgr_pkg::MODE_S16) begin
      v = {{16{in_sample_in[15]}}, in_sample_in[15:0]};
    end else begin
      v = in_sample_in;
    end
    neg = v[fgr_pkg::SAMPLE_W-1];
    mag = neg ? (~v + fgr_pkg::SAMPLE_W'(1)) : v;
  end

  // Full-scale gain passes the sample through unchanged
  assign k = fading ? (FADE_LAST - left_r + KW'(1)) : FADE_LAST;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      pos_r      <= '0;
      st_valid_r <= 1'b0;
    end else begin
      left_r <= left_nxt;
      pos_r  <= pos_nxt;
      if (in_ready) begin
        st_valid_r <= proc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      st_mag_r     <= mag;
      st_k_r       <= k;
      st_neg_r     <= neg;
      st_applied_r <= fading;
    end
  end

  assign st_valid   = st_valid_r;
  assign st_mag     = st_mag_r;
  assign st_k       = st_k_r;
  assign st_neg     = st_neg_r;
  assign st_applied = st_applied_r;

  a_arm_loads: assert property (@(posedge clk) disable iff (!rst_n)
    arm |=> (left_r == FADE_LAST) && (pos_r == '0))
    else $error("arm request did not restart the ramp");

  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= FADE_LAST)
    else $error("ramp frame count above fade length");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(pos_r) < MAX_EFF)
    else $error("channel position out of range");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !fading) |=> (left_r == '0))
    else $error("ramp armed without an arm request");

  a_applied_flag: assert property (@(posedge clk) disable iff (!rst_n)
    proc |=> st_valid_r && (st_applied_r == $past(fading)))
    else $error("captured sample lost or gain flag wrong");

endmodule

[hdl/fgr_scale.sv]
module fgr_scale (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 st_valid,
  output logic                                 st_ready,
  input  logic [fgr_pkg::SAMPLE_W-1:0]         st_mag,
  input  logic [fgr_pkg::GAIN_W-1:0]           st_k,
  input  logic                                 st_neg,
  input  logic                                 st_applied,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fgr_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                 out_fade_applied
);

  localparam int SW = fgr_pkg::SAMPLE_W;
  localparam int PW = fgr_pkg::SAMPLE_W + fgr_pkg::GAIN_W;

  logic [PW-1:0]  prod;
  logic [SW-1:0]  quo, res;
  logic           adv;
  logic           out_valid_r, out_applied_r;
  logic [SW-1:0]  out_sample_r;

  // Magnitude times gain step, then drop the low bits to divide by the fade
  // length; the quotient never exceeds the magnitude
  assign prod = PW'(st_mag) * PW'(st_k);
  assign quo  = prod[fgr_pkg::FADE_SHIFT +: SW];
  assign res  = st_neg ? (~quo + SW'(1)) : quo;

  assign adv      = !out_valid_r || out_ready;
  assign st_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && st_valid) begin
      out_sample_r  <= res;
      out_applied_r <= st_applied;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_out   = out_sample_r;
  assign out_fade_applied = out_applied_r;

endmodule

[hdl/fade_in_gain_ramp.sv]
// Channel  Handshake                  Payload
// in_      in_valid / in_ready        in_command, in_sample_in
// out_     out_valid / out_ready      out_sample_out, out_fade_applied
// cfg      psel, penable, pwrite      paddr, pwdata -> prdata (pready tied high)
//
// One request is taken per cycle while in_ready is high. A process request is
// captured in the input register when accepted and moves to the result register
// when that register is empty or out_ready is high; one 32x10 multiply and a
// shift that divides by the fade length produce the result. Arm requests update
// the ramp and produce no result.
// Reset is synchronous on rst_n: no fade armed, channel position zero,
// 16-bit mode, two channels. Low out_ready holds the result register, then the
// input register, and drops in_ready in the same cycle once both are full.
module fade_in_gain_ramp #(
  parameter int MAX_CHANNELS = fgr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [fgr_pkg::SAMPLE_W-1:0]  in_sample_in,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fgr_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                                 out_fade_applied,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fgr_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [fgr_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [fgr_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                 pready
);

  fgr_pkg::cfg_t                 cfg;
  logic                          st_valid, st_ready;
  logic [fgr_pkg::SAMPLE_W-1:0]  st_mag;
  logic [fgr_pkg::GAIN_W-1:0]    st_k;
  logic                          st_neg, st_applied;

  // Register file: sample width mode and channel count
  fgr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Ramp state, frame tracking and input capture; emits magnitude and gain
  fgr_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_sample_in (in_sample_in),
    .st_valid     (st_valid),
    .st_ready     (st_ready),
    .st_mag       (st_mag),
    .st_k         (st_k),
    .st_neg       (st_neg),
    .st_applied   (st_applied)
  );

  // Multiply by the gain step, divide by the fade length, restore the sign
  fgr_scale u_scale (
    .clk              (clk),
    .rst_n            (rst_n),
    .st_valid         (st_valid),
    .st_ready         (st_ready),
    .st_mag           (st_mag),
    .st_k             (st_k),
    .st_neg           (st_neg),
    .st_applied       (st_applied),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_fade_applied (out_fade_applied)
  );

endmodule
